// ----- rtl/core/twq_pkg.sv -----
// Shared types and constants for the timer wait queue.
// Used by twq_store and timer_wait_queue; depends on nothing.
package twq_pkg;

  localparam int unsigned DEFAULT_DEPTH = 32;
  localparam int unsigned TW = 31;
  localparam logic [TW-1:0] TICK_MAX = {TW{1'b1}};

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_QUERY = 2'd1,
    CMD_DELAY = 2'd2,
    CMD_UNTIL = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_WAKE = 2'd0,
    ST_TIME = 2'd1,
    ST_BAD  = 2'd2,
    ST_FULL = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_TK_RD,
    S_TK_CMP,
    S_TK_FIN,
    S_IN_RD,
    S_IN_CMP,
    S_IN_WR
  } state_t;

  typedef struct packed {
    cmd_t               command;
    logic [7:0]         task_id;
    logic signed [31:0] tick_argument;
  } req_t;

  typedef struct packed {
    logic [7:0]    target_task;
    status_t       status;
    logic [TW-1:0] time_value;
    logic          last;
  } rsp_t;

  typedef struct packed {
    logic [TW-1:0] deadline;
    logic [7:0]    task_id;
  } entry_t;

endpackage

// ----- rtl/core/twq_store.sv -----
// Circular waiter store addressed by position from the queue head.
// Depends on twq_pkg.
module twq_store #(
  parameter int unsigned DEPTH = twq_pkg::DEFAULT_DEPTH
) (
  input  logic                         clk,
  input  logic [$clog2(DEPTH)-1:0]     head,
  input  logic [$clog2(DEPTH+1)-1:0]   rd_idx,
  input  logic                         wr_en,
  input  logic [$clog2(DEPTH+1)-1:0]   wr_idx,
  input  twq_pkg::entry_t              wr_data,
  output twq_pkg::entry_t              rd_data
);
  import twq_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH+1);

  entry_t mem [DEPTH];

  function automatic logic [AW-1:0] phys(input logic [AW-1:0] h, input logic [CW-1:0] i);
    logic [CW:0] s;
    s = {{(CW+1-AW){1'b0}}, h} + {1'b0, i};
    if (s >= (CW+1)'(DEPTH)) s = s - (CW+1)'(DEPTH);
    return s[AW-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (wr_en) mem[phys(head, wr_idx)] <= wr_data;
    rd_data <= mem[phys(head, rd_idx)];
  end

endmodule

// ----- rtl/core/timer_wait_queue.sv -----
// Top level of the timer wait queue: command decode, tick counter, sorted store control.
// Depends on twq_pkg and twq_store.
//
// One command is taken when start is high and busy is low. A time query or a rejected
// request answers in the following cycle and busy stays low. An accepted delay or wait
// inserts into the sorted store by shifting later waiters up one slot at a time (a read
// then a compare-and-write on the single memory). The new waiter is written in the
// compare step once a waiter's deadline is not later, or in a final write step when it
// lands at the front; into an empty store it is written at accept and busy stays low.
// A tick on an empty store only advances the tick count and busy stays low; otherwise it
// reads and compares waiters from the head until one is not yet due or the store is empty;
// releases come one result at a time and the last release carries last. Results appear
// for one cycle with done high and cannot be held off.
module timer_wait_queue #(
  parameter int unsigned QUEUE_DEPTH = twq_pkg::DEFAULT_DEPTH
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  twq_pkg::req_t request,
  output logic          done,
  output twq_pkg::rsp_t reply
);
  import twq_pkg::*;

  localparam int unsigned AW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW = $clog2(QUEUE_DEPTH+1);

  state_t        state, state_next;
  logic [TW-1:0] tick, tick_next;
  logic [AW-1:0] head, head_next;
  logic [CW-1:0] count, count_next;
  logic [CW-1:0] idx, idx_next;
  logic          pend_valid, pend_valid_next;
  logic [7:0]    pend_task, pend_task_next;
  entry_t        new_ent, new_ent_next;
  logic          done_next;
  rsp_t          reply_next;

  logic          wr_en;
  logic [CW-1:0] wr_idx, rd_idx;
  entry_t        wr_data, rd_data;

  logic          accept;
  logic [TW:0]   sum;
  logic          arg_bad;
  logic [TW-1:0] dl;

  twq_store #(.DEPTH(QUEUE_DEPTH)) u_store (
    .clk     (clk),
    .head    (head),
    .rd_idx  (rd_idx),
    .wr_en   (wr_en),
    .wr_idx  (wr_idx),
    .wr_data (wr_data),
    .rd_data (rd_data)
  );

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  always_comb begin
    sum = {1'b0, tick} + {1'b0, request.tick_argument[TW-1:0]};
    if (request.command == CMD_DELAY) begin
      arg_bad = request.tick_argument[31] || (request.tick_argument == 32'sd0);
      dl      = sum[TW] ? TICK_MAX : sum[TW-1:0];
    end else begin
      arg_bad = request.tick_argument[31] || (request.tick_argument[TW-1:0] <= tick);
      dl      = request.tick_argument[TW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      tick       <= '0;
      head       <= '0;
      count      <= '0;
      pend_valid <= 1'b0;
      done       <= 1'b0;
    end else begin
      state      <= state_next;
      tick       <= tick_next;
      head       <= head_next;
      count      <= count_next;
      pend_valid <= pend_valid_next;
      done       <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    idx       <= idx_next;
    pend_task <= pend_task_next;
    new_ent   <= new_ent_next;
    reply     <= reply_next;
  end

  always_comb begin
    state_next      = state;
    tick_next       = tick;
    head_next       = head;
    count_next      = count;
    idx_next        = idx;
    pend_valid_next = pend_valid;
    pend_task_next  = pend_task;
    new_ent_next    = new_ent;
    done_next       = 1'b0;
    reply_next      = reply;
    wr_en           = 1'b0;
    wr_idx          = idx;
    wr_data         = new_ent;
    rd_idx          = '0;

    unique case (state)
      S_IDLE: begin
        if (accept) begin
          reply_next = '{target_task: request.task_id, status: ST_BAD,
                         time_value: '0, last: 1'b1};
          unique case (request.command)
            CMD_TICK: begin
              tick_next       = (tick == TICK_MAX) ? tick : tick + TW'(1);
              pend_valid_next = 1'b0;
              if (count != '0) state_next = S_TK_RD;
            end
            CMD_QUERY: begin
              done_next             = 1'b1;
              reply_next.status     = ST_TIME;
              reply_next.time_value = tick;
            end
            CMD_DELAY, CMD_UNTIL: begin
              new_ent_next = '{deadline: dl, task_id: request.task_id};
              idx_next     = count;
              if (arg_bad) begin
                done_next = 1'b1;
              end else if (count == CW'(QUEUE_DEPTH)) begin
                done_next         = 1'b1;
                reply_next.status = ST_FULL;
              end else if (count == '0) begin
                wr_en      = 1'b1;
                wr_idx     = '0;
                wr_data    = '{deadline: dl, task_id: request.task_id};
                count_next = CW'(1);
              end else begin
                state_next = S_IN_RD;
              end
            end
            default: ;
          endcase
        end
      end

      S_TK_RD: begin
        rd_idx     = '0;
        state_next = S_TK_CMP;
      end

      S_TK_CMP: begin
        if (rd_data.deadline <= tick) begin
          // Emit the previous release; this one may turn out to be the last.
          if (pend_valid) begin
            done_next  = 1'b1;
            reply_next = '{target_task: pend_task, status: ST_WAKE,
                           time_value: '0, last: 1'b0};
          end
          pend_valid_next = 1'b1;
          pend_task_next  = rd_data.task_id;
          head_next       = (head == AW'(QUEUE_DEPTH-1)) ? '0 : head + AW'(1);
          count_next      = count - CW'(1);
          state_next      = (count == CW'(1)) ? S_TK_FIN : S_TK_RD;
        end else begin
          if (pend_valid) begin
            done_next  = 1'b1;
            reply_next = '{target_task: pend_task, status: ST_WAKE,
                           time_value: '0, last: 1'b1};
          end
          pend_valid_next = 1'b0;
          state_next      = S_IDLE;
        end
      end

      S_TK_FIN: begin
        done_next       = 1'b1;
        reply_next      = '{target_task: pend_task, status: ST_WAKE,
                            time_value: '0, last: 1'b1};
        pend_valid_next = 1'b0;
        state_next      = S_IDLE;
      end

      S_IN_RD: begin
        rd_idx     = idx - CW'(1);
        state_next = S_IN_CMP;
      end

      S_IN_CMP: begin
        if (rd_data.deadline > new_ent.deadline) begin
          // Shift the later waiter up one slot.
          wr_en      = 1'b1;
          wr_data    = rd_data;
          idx_next   = idx - CW'(1);
          state_next = (idx == CW'(1)) ? S_IN_WR : S_IN_RD;
        end else begin
          wr_en      = 1'b1;
          count_next = count + CW'(1);
          state_next = S_IDLE;
        end
      end

      S_IN_WR: begin
        wr_en      = 1'b1;
        count_next = count + CW'(1);
        state_next = S_IDLE;
      end

      default: state_next = S_IDLE;
    endcase
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(QUEUE_DEPTH)) else $error("store count beyond depth");

  a_idle_no_pend: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> !pend_valid) else $error("pending release left in idle");

  a_single_last: assert property (@(posedge clk) disable iff (rst)
    done && reply.status != ST_WAKE |-> reply.last) else $error("non-wake reply without last");

  a_tick_mono: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> tick >= $past(tick)) else $error("tick count went backward");

endmodule
